// ----- hdl/range_count_less_scaled_update_unit_assert.svh -----
// Assertion macros used by the range_count_less_scaled_update_unit module.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RANGE_COUNT_LESS_SCALED_UPDATE_UNIT_ASSERT_SVH
`define RANGE_COUNT_LESS_SCALED_UPDATE_UNIT_ASSERT_SVH

`define RCLSU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define RCLSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rclsu_pkg.sv -----
`default_nettype none

package rclsu_pkg;

  localparam int unsigned MaxSlots = 1024;
  localparam int unsigned AddrW    = $clog2(MaxSlots);

  localparam int unsigned SlotW    = 10;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned LenW     = SlotW + 1;
  localparam int unsigned ProdW    = DataW + LenW;
  localparam int unsigned ElemCntW = 11;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CmdW-1:0] {
    CmdLoad  = 2'd0,
    CmdXform = 2'd1,
    CmdRead  = 2'd2
  } cmd_e;

  localparam logic [CfgIdxW-1:0] CfgElementCount = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMultiplier   = 1'd1;

  function automatic logic slot_exists(input logic [SlotW-1:0] s);
    logic [31:0] ext;
    ext = {{(32-SlotW){1'b0}}, s};
    return ext < MaxSlots;
  endfunction

  function automatic logic [AddrW-1:0] to_addr(input logic [SlotW-1:0] s);
    logic [SlotW+AddrW-1:0] ext;
    ext = {{AddrW{1'b0}}, s};
    return ext[AddrW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/rclsu_in_if.sv -----
`default_nettype none

interface rclsu_in_if;
  logic                        valid;
  logic                        ready;
  logic [rclsu_pkg::CmdW-1:0]  cmd;
  logic [rclsu_pkg::SlotW-1:0] slot;
  logic [rclsu_pkg::DataW-1:0] data_in;
  logic [rclsu_pkg::SlotW-1:0] range_low;
  logic [rclsu_pkg::SlotW-1:0] range_high;

  modport source (output valid, cmd, slot, data_in, range_low, range_high, input ready);
  modport sink (input valid, cmd, slot, data_in, range_low, range_high, output ready);
endinterface

`default_nettype wire

// ----- hdl/rclsu_out_if.sv -----
`default_nettype none

interface rclsu_out_if;
  logic                        valid;
  logic                        ready;
  logic [rclsu_pkg::DataW-1:0] data_out;
  logic                        written;
  logic                        range_error;

  modport source (output valid, data_out, written, range_error, input ready);
  modport sink (input valid, data_out, written, range_error, output ready);
endinterface

`default_nettype wire

// ----- hdl/rclsu_ram.sv -----
`default_nettype none

module rclsu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/rclsu_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rclsu_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [rclsu_pkg::ProdW-1:0] dividend_i,
  input  wire logic [rclsu_pkg::LenW-1:0]  divisor_i,
  output logic                             done_o,
  output logic      [rclsu_pkg::DataW-1:0] quotient_o
);

  localparam int unsigned StepW = $clog2(rclsu_pkg::ProdW);

  logic                          run_q;
  logic                          done_q;
  logic [StepW-1:0]              step_q;
  logic [rclsu_pkg::LenW-1:0]    rem_q;
  logic [rclsu_pkg::LenW-1:0]    dvs_q;
  logic [rclsu_pkg::ProdW-1:0]   quo_q;

  logic [rclsu_pkg::LenW:0]      shifted;
  logic [rclsu_pkg::LenW:0]      diff;
  logic                          qbit;
  logic [rclsu_pkg::LenW-1:0]    rem_d;

  always_comb begin
    shifted = {rem_q, quo_q[rclsu_pkg::ProdW-1]};
    diff    = shifted - {1'b0, dvs_q};
    qbit    = !diff[rclsu_pkg::LenW];
    rem_d   = qbit ? diff[rclsu_pkg::LenW-1:0] : shifted[rclsu_pkg::LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        step_q <= StepW'(rclsu_pkg::ProdW - 1);
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (run_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[rclsu_pkg::ProdW-2:0], qbit};
        if (step_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q[rclsu_pkg::DataW-1:0];

endmodule

`default_nettype wire

// ----- hdl/range_count_less_scaled_update_unit.sv -----
// Channel   Dir  Payload                                      Transfer
// in_if     in   cmd, slot, data_in, range_low, range_high     valid & ready
// out_if    out  data_out, written, range_error               valid & ready
// cfg       in   cfg_idx_i, cfg_data_i                         cfg_we_i
//
// One item is in work at a time; a new item is taken while a result waits in the output register.
// A load, an empty range or an unused command goes from idle to the push state, and a read first
// passes the read state. A transform reads one stored value per cycle from the RAM port as it
// scans the range, then takes the multiply state and the 43 divider steps before the push state.
// Reset clears the registers outside the RAM; stored values are undefined until loaded.
// A stalled output holds its result and stops further items from finishing.
`default_nettype none
`include "range_count_less_scaled_update_unit_assert.svh"

module range_count_less_scaled_update_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  rclsu_in_if.sink                           in_if,
  rclsu_out_if.source                        out_if,
  input  wire logic                          cfg_we_i,
  input  wire logic [rclsu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rclsu_pkg::DataW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StMul,
    StDiv,
    StPush
  } state_e;

  state_e                           state_q;
  logic [rclsu_pkg::SlotW-1:0]      idx_q;
  logic [rclsu_pkg::SlotW-1:0]      hi_q;
  logic [rclsu_pkg::SlotW-1:0]      slot_q;
  logic [rclsu_pkg::DataW-1:0]      thr_q;
  logic [rclsu_pkg::LenW-1:0]       len_q;
  logic [rclsu_pkg::LenW-1:0]       cnt_q;
  logic [rclsu_pkg::DataW-1:0]      res_data_q;
  logic                             res_wr_q;
  logic                             res_err_q;
  logic                             out_valid_q;
  logic [rclsu_pkg::DataW-1:0]      out_data_q;
  logic                             out_wr_q;
  logic                             out_err_q;
  logic [rclsu_pkg::ElemCntW-1:0]   elem_cnt_q;
  logic [rclsu_pkg::DataW-1:0]      mult_q;

  logic                             in_fire;
  logic                             out_free;
  logic                             ram_we;
  logic [rclsu_pkg::AddrW-1:0]      ram_waddr;
  logic [rclsu_pkg::DataW-1:0]      ram_wdata;
  logic [rclsu_pkg::AddrW-1:0]      ram_raddr;
  logic [rclsu_pkg::DataW-1:0]      ram_rdata;
  logic [rclsu_pkg::SlotW-1:0]      idx_next;
  logic                             hit;
  logic [rclsu_pkg::LenW-1:0]       cnt_next;
  logic                             wb_ok;
  logic                             div_start;
  logic [rclsu_pkg::ProdW-1:0]      product;
  logic                             div_done;
  logic [rclsu_pkg::DataW-1:0]      div_quo;

  assign in_fire   = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;
  assign idx_next  = idx_q + rclsu_pkg::SlotW'(1);
  assign hit       = rclsu_pkg::slot_exists(idx_q) && (ram_rdata < thr_q);
  assign cnt_next  = cnt_q + rclsu_pkg::LenW'(hit);
  assign wb_ok     = ({1'b0, slot_q} < elem_cnt_q) && rclsu_pkg::slot_exists(slot_q);
  assign div_start = (state_q == StMul);
  assign product   = {{rclsu_pkg::LenW{1'b0}}, mult_q} * {{rclsu_pkg::DataW{1'b0}}, cnt_q};

  assign in_if.ready        = (state_q == StIdle);
  assign out_if.valid       = out_valid_q;
  assign out_if.data_out    = out_data_q;
  assign out_if.written     = out_wr_q;
  assign out_if.range_error = out_err_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rclsu_pkg::to_addr(slot_q);
    ram_wdata = div_quo;
    ram_raddr = rclsu_pkg::to_addr(idx_q);
    case (state_q)
      StIdle: begin
        if (in_if.cmd == rclsu_pkg::CmdXform) begin
          ram_raddr = rclsu_pkg::to_addr(in_if.range_low);
        end else begin
          ram_raddr = rclsu_pkg::to_addr(in_if.slot);
        end
        if (in_fire && in_if.cmd == rclsu_pkg::CmdLoad
            && rclsu_pkg::slot_exists(in_if.slot)) begin
          ram_we    = 1'b1;
          ram_waddr = rclsu_pkg::to_addr(in_if.slot);
          ram_wdata = in_if.data_in;
        end
      end
      StScan: begin
        ram_raddr = rclsu_pkg::to_addr(idx_next);
      end
      StDiv: begin
        ram_we = div_done && wb_ok;
      end
      default: begin
      end
    endcase
  end

  rclsu_ram #(
    .Width (rclsu_pkg::DataW),
    .Depth (rclsu_pkg::MaxSlots)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  rclsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (len_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      hi_q        <= '0;
      slot_q      <= '0;
      thr_q       <= '0;
      len_q       <= '0;
      cnt_q       <= '0;
      res_data_q  <= '0;
      res_wr_q    <= 1'b0;
      res_err_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_wr_q    <= 1'b0;
      out_err_q   <= 1'b0;
      elem_cnt_q  <= rclsu_pkg::ElemCntW'(1024);
      mult_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rclsu_pkg::CfgElementCount: elem_cnt_q <= cfg_data_i[rclsu_pkg::ElemCntW-1:0];
          rclsu_pkg::CfgMultiplier:   mult_q     <= cfg_data_i;
          default: begin
          end
        endcase
      end

      if (out_valid_q && out_if.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (in_fire) begin
            slot_q     <= in_if.slot;
            res_data_q <= '0;
            res_wr_q   <= 1'b0;
            res_err_q  <= 1'b0;
            state_q    <= StPush;
            case (in_if.cmd)
              rclsu_pkg::CmdLoad: begin
                res_data_q <= in_if.data_in;
                res_wr_q   <= rclsu_pkg::slot_exists(in_if.slot);
              end
              rclsu_pkg::CmdRead: begin
                state_q <= StRead;
              end
              rclsu_pkg::CmdXform: begin
                if (in_if.range_low > in_if.range_high) begin
                  res_err_q <= 1'b1;
                end else begin
                  idx_q   <= in_if.range_low;
                  hi_q    <= in_if.range_high;
                  thr_q   <= in_if.data_in;
                  len_q   <= {1'b0, in_if.range_high} - {1'b0, in_if.range_low}
                             + rclsu_pkg::LenW'(1);
                  cnt_q   <= '0;
                  state_q <= StScan;
                end
              end
              default: begin
              end
            endcase
          end
        end
        StRead: begin
          res_data_q <= rclsu_pkg::slot_exists(slot_q) ? ram_rdata : '0;
          state_q    <= StPush;
        end
        StScan: begin
          cnt_q <= cnt_next;
          if (idx_q == hi_q) begin
            state_q <= StMul;
          end else begin
            idx_q <= idx_next;
          end
        end
        StMul: begin
          state_q <= StDiv;
        end
        StDiv: begin
          if (div_done) begin
            res_data_q <= div_quo;
            res_wr_q   <= wb_ok;
            res_err_q  <= 1'b0;
            state_q    <= StPush;
          end
        end
        StPush: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_data_q;
            out_wr_q    <= res_wr_q;
            out_err_q   <= res_err_q;
            state_q     <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  `RCLSU_ASSERT_SAME(a_scan_bound, state_q == StScan, idx_q <= hi_q, "Scan ran past the range.")
  `RCLSU_ASSERT_SAME(a_count_bound, state_q == StScan, cnt_q < len_q, "Count overran the range.")
  `RCLSU_ASSERT_NEXT(a_push_result, state_q == StPush && out_free,
                     out_valid_q && state_q == StIdle,
                     "Finished result did not reach the output register.")
  `RCLSU_ASSERT_SAME(a_div_owner, div_done, state_q == StDiv,
                     "Divider finished while no transform waited for it.")

endmodule

`default_nettype wire

// ----- bench/rclsu_result_checker.sv -----
`timescale 1ns / 100ps

module rclsu_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rclsu_in_if                           in_mon,
  rclsu_out_if                          out_mon,
  input  logic                          cfg_we_i,
  input  logic [rclsu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rclsu_pkg::DataW-1:0]   cfg_data_i,
  output int                            mismatches_o,
  output int                            pending_o
);
  import rclsu_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] data_out;
    logic             written;
    logic             range_error;
  } result_t;

  logic [DataW-1:0]    stored [MaxSlots];
  logic [ElemCntW-1:0] slots_in_use;
  logic [DataW-1:0]    scale;
  result_t             awaited_q [$];
  int                  mismatches;

  function automatic result_t apply_item(input logic [CmdW-1:0]  cmd,
                                         input logic [SlotW-1:0] slot,
                                         input logic [DataW-1:0] data,
                                         input logic [SlotW-1:0] lo,
                                         input logic [SlotW-1:0] hi);
    result_t         res;
    logic [LenW-1:0] below;
    logic [63:0]     span;
    logic [63:0]     scaled;
    res = '0;
    below = '0;
    case (cmd)
      CmdLoad: begin
        res.data_out = data;
        res.written = 1'b1;
        stored[slot] = data;
      end
      CmdRead: begin
        res.data_out = stored[slot];
      end
      CmdXform: begin
        if (lo > hi) begin
          res.range_error = 1'b1;
        end else begin
          for (int i = int'(lo); i <= int'(hi); i++) begin
            if (stored[SlotW'(i)] < data) begin
              below++;
            end
          end
          span = 64'(hi) - 64'(lo) + 64'd1;
          scaled = {32'd0, scale} * 64'(below) / span;
          res.data_out = scaled[DataW-1:0];
          if ({1'b0, slot} < slots_in_use) begin
            res.written = 1'b1;
            stored[slot] = res.data_out;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    result_t fresh;
    if (!rst_ni) begin
      awaited_q.delete();
      slots_in_use = 11'd1024;
      scale = '0;
      mismatches = 0;
      pending_o <= 0;
      mismatches_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgElementCount) begin
          slots_in_use = cfg_data_i[ElemCntW-1:0];
        end else if (cfg_idx_i == CfgMultiplier) begin
          scale = cfg_data_i;
        end
      end
      // A result transfer is matched before this edge's input transfer is predicted.
      if (out_mon.valid && out_mon.ready) begin
        got.data_out = out_mon.data_out;
        got.written = out_mon.written;
        got.range_error = out_mon.range_error;
        if (awaited_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result: data_out %h written %b range_error %b",
                     got.data_out, got.written, got.range_error);
          end
          mismatches++;
        end else begin
          want = awaited_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10) begin
              $display("mismatch (data_out written range_error): expected %h %b %b, got %h %b %b",
                       want.data_out, want.written, want.range_error,
                       got.data_out, got.written, got.range_error);
            end
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        fresh = apply_item(in_mon.cmd, in_mon.slot, in_mon.data_in,
                           in_mon.range_low, in_mon.range_high);
        awaited_q = {awaited_q, fresh};
      end
      pending_o <= awaited_q.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

// ----- bench/range_count_less_scaled_update_unit_tb.sv -----
`timescale 1ns / 100ps

module range_count_less_scaled_update_unit_tb;
  import rclsu_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam int HoldCycles     = 300;
  localparam int ItemsPerPhase  = 54;
  localparam int BigRangeBudget = 20;
  localparam int WindowSlots    = 256;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [DataW-1:0]    cfg_data_i;
  int                  mismatches;
  int                  pending;
  bit                  quiet = 1'b0;
  int                  hold_requests = 0;
  int                  big_ranges_left = BigRangeBudget;

  rclsu_in_if  in_ch ();
  rclsu_out_if out_ch ();

  range_count_less_scaled_update_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  rclsu_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  task automatic send_item(input logic [CmdW-1:0]  cmd,
                           input logic [SlotW-1:0] slot,
                           input logic [DataW-1:0] data,
                           input logic [SlotW-1:0] lo,
                           input logic [SlotW-1:0] hi);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.slot <= slot;
    in_ch.data_in <= data;
    in_ch.range_low <= lo;
    in_ch.range_high <= hi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ElemCntW-1:0] count, input logic [DataW-1:0] mult);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgElementCount;
    cfg_data_i <= {{(DataW-ElemCntW){1'b0}}, count};
    @(posedge clk_i);
    cfg_idx_i <= CfgMultiplier;
    cfg_data_i <= mult;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random reads and range scans stay inside the window of slots that were loaded.
  task automatic random_item();
    int             pick;
    int             last;
    logic [SlotW-1:0] lo;
    logic [SlotW-1:0] hi;
    pick = $urandom_range(0, 99);
    lo = SlotW'($urandom);
    hi = SlotW'($urandom);
    if (pick < 30) begin
      send_item(CmdLoad, SlotW'($urandom_range(0, WindowSlots - 1)), pick_value(), lo, hi);
    end else if (pick < 45) begin
      send_item(CmdRead, SlotW'($urandom_range(0, WindowSlots - 1)), $urandom, lo, hi);
    end else if (pick < 96) begin
      if ($urandom_range(0, 14) == 0) begin
        lo = SlotW'($urandom_range(1, 1023));
        hi = SlotW'($urandom_range(0, int'(lo) - 1));
      end else if (big_ranges_left > 0 && $urandom_range(0, 9) == 0) begin
        big_ranges_left--;
        if ($urandom_range(0, 2) == 0) begin
          lo = '0;
          hi = SlotW'(WindowSlots - 1);
        end else begin
          lo = SlotW'($urandom_range(0, 15));
          hi = SlotW'($urandom_range(WindowSlots - 16, WindowSlots - 1));
        end
      end else begin
        lo = SlotW'($urandom_range(0, WindowSlots - 1));
        last = int'(lo) + int'($urandom_range(0, 63));
        hi = SlotW'((last > WindowSlots - 1) ? WindowSlots - 1 : last);
      end
      send_item(CmdXform, SlotW'($urandom), pick_value(), lo, hi);
    end else begin
      send_item(CmdUnused, SlotW'($urandom), $urandom, lo, hi);
    end
  endtask

  // The result side idles in short bursts unless quiet is set, and holds off for a long stretch on request.
  initial begin
    int holds_done;
    holds_done = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CmdLoad;
    in_ch.slot <= '0;
    in_ch.data_in <= '0;
    in_ch.range_low <= '0;
    in_ch.range_high <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgElementCount;
    cfg_data_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(CmdLoad, 10'd0, 32'h0000_0000, '0, '0);
    send_item(CmdLoad, 10'd1, 32'hFFFF_FFFF, '1, '1);
    send_item(CmdLoad, 10'd2, 32'd5, '0, '1);
    send_item(CmdLoad, 10'd3, 32'd1000, '1, '0);
    send_item(CmdLoad, 10'd1023, 32'hA5A5_A5A5, '0, '0);
    send_item(CmdLoad, 10'd1022, 32'h5A5A_5A5A, '0, '0);
    send_item(CmdRead, 10'd1023, '1, '1, '1);
    send_item(CmdRead, 10'd0, '0, '0, '0);
    send_item(CmdRead, 10'd1, '0, '0, '0);
    send_item(CmdXform, 10'd4, 32'd6, 10'd0, 10'd3);

    drain();
    configure(11'd1024, 32'hFFFF_FFFF);
    send_item(CmdXform, 10'd5, 32'hFFFF_FFFF, 10'd0, 10'd3);
    send_item(CmdXform, 10'd6, 32'h0000_0000, 10'd0, 10'd3);
    send_item(CmdXform, 10'd1022, 32'hFFFF_FFFF, 10'd1022, 10'd1023);
    send_item(CmdXform, 10'd7, 32'd6, 10'd1023, 10'd0);
    send_item(CmdXform, 10'd7, 32'd6, 10'd1, 10'd0);
    send_item(CmdUnused, '1, '1, '1, '1);
    send_item(CmdXform, 10'd7, 32'd6, 10'd2, 10'd2);
    send_item(CmdRead, 10'd1022, '0, '0, '0);

    drain();
    configure(11'd1, 32'd1);
    send_item(CmdXform, 10'd0, 32'd6, 10'd0, 10'd3);
    send_item(CmdXform, 10'd1, 32'd1001, 10'd0, 10'd3);
    send_item(CmdXform, 10'd1023, 32'hFFFF_FFFF, 10'd0, 10'd3);
    send_item(CmdLoad, 10'd1023, 32'd77, '0, '0);

    // Every slot of the window gets a value before any random read or range scan.
    drain();
    configure(11'd1024, $urandom);
    for (int s = 0; s < WindowSlots; s++) begin
      send_item(CmdLoad, SlotW'(s), pick_value(), SlotW'($urandom), SlotW'($urandom));
    end

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: configure(11'd1024, $urandom);
        1: configure(11'd1, 32'hFFFF_FFFF);
        2: configure(ElemCntW'($urandom_range(2, 1023)), 32'd0);
        3: configure(11'd128, $urandom_range(1, 1000));
        default: configure(ElemCntW'($urandom_range(1, 1024)), $urandom);
      endcase
      if (p == 3) begin
        hold_requests <= hold_requests + 1;
      end
      if (p == 4) begin
        quiet <= 1'b1;
      end
      repeat (ItemsPerPhase) random_item();
    end

    in_ch.valid <= 1'b0;
    for (int n = 0; n < 5000 && pending != 0; n++) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("range_count_less_scaled_update_unit test passed");
    end else begin
      $display("range_count_less_scaled_update_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("range_count_less_scaled_update_unit test failed");
    $finish;
  end

endmodule
